[src/inode_block_allocator_assert.svh]
// Assertion macros used by the checker file.
`ifndef INODE_BLOCK_ALLOCATOR_ASSERT_SVH
`define INODE_BLOCK_ALLOCATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define IBA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define IBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/iba_pkg.sv]
package iba_pkg;

    localparam int INODE_SLOTS_DEF = 16;
    localparam int DISK_BLOCKS_DEF = 128;
    localparam int NAME_BYTES_DEF = 8;
    localparam int POINTERS_PER_FILE_DEF = 8;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_MAP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_INODE    = 3'd1,
        ST_NAME_EXISTS = 3'd2,
        ST_NO_SPACE    = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_BAD_INDEX   = 3'd5,
        ST_BAD_SIZE    = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] file_name;
        logic [3:0]  block_count;
        logic [2:0]  block_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] physical_block;
    } out_item_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_BSCAN,
        S_COMMIT,
        S_FREE_RD,
        S_FREE_WR,
        S_MAP_RD,
        S_MAP_WAIT,
        S_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic init_step;   // initialize one bitmap entry after reset
        logic load;        // latch input item
        logic scan_clr;    // reset inode scan
        logic scan_step;   // look at one inode slot
        logic bscan_clr;   // reset bitmap scan
        logic bscan_step;  // look at one bitmap entry
        logic commit;      // write one pointer, mark its block (one per cycle)
        logic commit_fin;  // set used, size, name
        logic free_rd;     // read pointer of deleted file
        logic free_wr;     // clear block in bitmap
        logic free_fin;    // clear used flag
        logic map_rd;      // read mapped pointer
        logic res_set;     // set result
        logic [2:0] res_status;
        logic res_from_ptr;
        logic out_valid_set;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic init_done;
        logic [1:0] opcode;
        logic scan_done;
        logic have_free;
        logic have_match;
        logic count_ok;
        logic bscan_done;
        logic bscan_enough;
        logic commit_done;
        logic free_done;
        logic idx_ok;
    } sts_t;

endpackage

[src/iba_datapath.sv]
module iba_datapath
    import iba_pkg::*;
#(
    parameter int INODE_SLOTS = INODE_SLOTS_DEF,
    parameter int DISK_BLOCKS = DISK_BLOCKS_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    parameter int POINTERS_PER_FILE = POINTERS_PER_FILE_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_item_t out_item
);
    localparam int IW = $clog2(INODE_SLOTS);
    localparam int BW = $clog2(DISK_BLOCKS);
    localparam int PW = (POINTERS_PER_FILE > 1) ? $clog2(POINTERS_PER_FILE) : 1;
    localparam int PCW = $clog2(POINTERS_PER_FILE + 1);
    localparam int PAW = IW + PW;
    localparam int PDEPTH = INODE_SLOTS << PW;

    // Inode flags and metadata (used flags reset, others written by create)
    logic [INODE_SLOTS-1:0] used_reg;
    logic [63:0]  name_mem [INODE_SLOTS];
    logic [PCW-1:0] size_mem [INODE_SLOTS];
    logic [BW-1:0]  ptr_mem [PDEPTH];

    // Block bitmap, rebuilt by a clearing pass after reset
    logic          busy_mem [DISK_BLOCKS];
    logic          busy_rd_reg;
    logic [BW-1:0] chk_idx_reg;
    logic          chk_valid_reg;
    logic [BW-1:0] init_reg;

    logic [1:0]  op_reg;
    logic [63:0] name_reg;
    logic [3:0]  count_reg;
    logic [2:0]  idx_reg;

    logic [IW:0]  scan_reg;
    logic         have_free_reg, have_match_reg;
    logic [IW-1:0] free_slot_reg, match_slot_reg;
    logic [BW:0]  bscan_reg;
    logic [PCW-1:0] found_reg;
    logic [BW-1:0] picks_reg [POINTERS_PER_FILE];
    logic [PCW-1:0] cptr_reg;
    logic [BW-1:0] rd_ptr_reg;
    logic [2:0]  res_status_reg;
    logic [6:0]  res_value_reg;

    // Name normalization: keep bytes up to the first zero byte
    logic [63:0] norm_name;
    always_comb begin
        logic stop;
        stop = 1'b0;
        norm_name = '0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (in_item.file_name[8*b +: 8] == 8'd0) stop = 1'b1;
            if (!stop) norm_name[8*b +: 8] = in_item.file_name[8*b +: 8];
        end
    end

    logic [IW-1:0] scan_idx;
    assign scan_idx = scan_reg[IW-1:0];
    logic [BW-1:0] bidx;
    assign bidx = bscan_reg[BW-1:0];
    logic bscan_end;
    assign bscan_end = (bscan_reg >= (BW+1)'(DISK_BLOCKS));
    logic pick_enough;
    assign pick_enough = (32'(found_reg) >= 32'(count_reg));
    logic [PW-1:0] cptr_idx;
    assign cptr_idx = cptr_reg[PW-1:0];
    logic [PW-1:0] map_idx;
    assign map_idx = PW'(idx_reg);
    logic [IW-1:0] commit_slot;
    assign commit_slot = free_slot_reg;
    logic [PCW-1:0] match_size;
    assign match_size = size_mem[match_slot_reg];

    // Control and flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            init_reg <= '0;
        end else begin
            if (cmd.init_step) init_reg <= init_reg + 1'b1;
            if (cmd.commit_fin) used_reg[commit_slot] <= 1'b1;
            if (cmd.free_fin) used_reg[match_slot_reg] <= 1'b0;
        end
    end

    // Block bitmap: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.init_step) busy_mem[init_reg] <= (init_reg == '0);
        if (cmd.commit) busy_mem[picks_reg[cptr_idx]] <= 1'b1;
        if (cmd.free_wr) busy_mem[rd_ptr_reg] <= 1'b0;
        busy_rd_reg <= busy_mem[bidx];
        chk_idx_reg <= bidx;
    end

    // Inode metadata and pointer memories
    always_ff @(posedge aclk) begin
        if (cmd.commit) ptr_mem[PAW'({commit_slot, cptr_idx})] <= picks_reg[cptr_idx];
        if (cmd.commit_fin) begin
            name_mem[commit_slot] <= name_reg;
            size_mem[commit_slot] <= PCW'(count_reg);
        end
        if (cmd.free_rd) rd_ptr_reg <= ptr_mem[PAW'({match_slot_reg, cptr_idx})];
        if (cmd.map_rd) rd_ptr_reg <= ptr_mem[PAW'({match_slot_reg, map_idx})];
    end

    // Scans, counters and result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_item.opcode;
            name_reg <= norm_name;
            count_reg <= in_item.block_count;
            idx_reg <= in_item.block_index;
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
            have_free_reg <= 1'b0;
            have_match_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            scan_reg <= scan_reg + 1'b1;
            if (!used_reg[scan_idx] && !have_free_reg) begin
                have_free_reg <= 1'b1;
                free_slot_reg <= scan_idx;
            end
            if (used_reg[scan_idx] && name_mem[scan_idx] == name_reg && !have_match_reg) begin
                have_match_reg <= 1'b1;
                match_slot_reg <= scan_idx;
            end
        end
        // Bitmap scan: address issued one cycle, entry checked the next
        if (cmd.bscan_clr) begin
            bscan_reg <= (BW+1)'(1);
            found_reg <= '0;
            cptr_reg <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            chk_valid_reg <= cmd.bscan_step && !bscan_end;
            if (cmd.bscan_step && !bscan_end) bscan_reg <= bscan_reg + 1'b1;
            if (chk_valid_reg && !busy_rd_reg && !pick_enough) begin
                picks_reg[found_reg[PW-1:0]] <= chk_idx_reg;
                found_reg <= found_reg + 1'b1;
            end
            if (cmd.commit || cmd.free_wr) cptr_reg <= cptr_reg + 1'b1;
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            if (cmd.res_status != ST_OK) res_value_reg <= '0;
            else if (cmd.res_from_ptr) res_value_reg <= 7'(rd_ptr_reg);
            else if (op_reg == OP_CREATE) res_value_reg <= 7'(free_slot_reg);
            else if (op_reg == OP_DELETE) res_value_reg <= 7'(match_slot_reg);
            else res_value_reg <= '0;
        end
    end

    always_comb begin
        sts.init_done = (init_reg == BW'(DISK_BLOCKS - 1));
        sts.opcode = op_reg;
        sts.scan_done = (scan_reg == (IW+1)'(INODE_SLOTS - 1));
        sts.have_free = have_free_reg;
        sts.have_match = have_match_reg;
        sts.count_ok = (count_reg != 4'd0) && (32'(count_reg) <= POINTERS_PER_FILE);
        sts.bscan_enough = pick_enough;
        sts.bscan_done = bscan_end && !chk_valid_reg;
        sts.commit_done = (32'(cptr_reg) + 1 >= 32'(count_reg));
        sts.free_done = (cptr_reg >= match_size);
        sts.idx_ok = (32'(idx_reg) < 32'(match_size));
        out_item.status = res_status_reg;
        out_item.physical_block = res_value_reg;
    end

endmodule

[src/iba_controller.sv]
module iba_controller
    import iba_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_INIT;
        else state_reg <= state_next;
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.bscan_clr = 1'b1;
                cmd.res_set = 1'b1;
                state_next = S_OUT;
                case (sts.opcode)
                    OP_CREATE: begin
                        if (!sts.have_free) cmd.res_status = ST_NO_INODE;
                        else if (sts.have_match) cmd.res_status = ST_NAME_EXISTS;
                        else if (!sts.count_ok) cmd.res_status = ST_BAD_SIZE;
                        else begin
                            cmd.res_set = 1'b0;
                            state_next = S_BSCAN;
                        end
                    end
                    OP_DELETE: begin
                        if (!sts.have_match) cmd.res_status = ST_NOT_FOUND;
                        else begin
                            cmd.res_set = 1'b0;
                            state_next = S_FREE_RD;
                        end
                    end
                    OP_MAP: begin
                        if (!sts.have_match) cmd.res_status = ST_NOT_FOUND;
                        else if (!sts.idx_ok) cmd.res_status = ST_BAD_INDEX;
                        else begin
                            cmd.res_set = 1'b0;
                            cmd.map_rd = 1'b1;
                            state_next = S_MAP_WAIT;
                        end
                    end
                    default: cmd.res_status = ST_OK;
                endcase
            end
            S_BSCAN: begin
                if (sts.bscan_enough) state_next = S_COMMIT;
                else if (sts.bscan_done) begin
                    cmd.res_set = 1'b1;
                    cmd.res_status = ST_NO_SPACE;
                    state_next = S_OUT;
                end else cmd.bscan_step = 1'b1;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                if (sts.commit_done) begin
                    cmd.commit_fin = 1'b1;
                    cmd.res_set = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next = S_OUT;
                end
            end
            S_FREE_RD: begin
                if (sts.free_done) begin
                    cmd.free_fin = 1'b1;
                    cmd.res_set = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next = S_OUT;
                end else begin
                    cmd.free_rd = 1'b1;
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                cmd.free_wr = 1'b1;
                state_next = S_FREE_RD;
            end
            S_MAP_WAIT: begin
                cmd.res_set = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_from_ptr = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[src/inode_block_allocator.sv]
// inode_block_allocator: flat file table with a first-fit block bitmap.
// Input channel s_valid/s_ready/s_item carries one operation item:
// create, delete or map, with the file name, block count and index.
// Output channel m_valid/m_ready/m_item returns one status item per
// operation: status code and a physical block (map) or inode slot.
// One item is processed at a time. Every operation first scans all
// INODE_SLOTS slots, one per cycle, for a free slot and a name match.
// Create then scans the bitmap from block 1, one entry per cycle with a
// registered read, until enough free blocks are found or the bitmap
// ends, and commits one pointer per cycle. Delete frees each block by
// reading its pointer and then clearing its bitmap entry.
// s_ready rises in the cycle right after the result is taken.
// Reset (aresetn low, synchronous) clears all inode used flags; then a
// clearing pass over every bitmap entry rebuilds the bitmap with block 0
// reserved, and s_ready stays low until it ends.
// If the receiver stalls, the result holds in its register and no new
// item is accepted until it is taken.
module inode_block_allocator
    import iba_pkg::*;
#(
    parameter int INODE_SLOTS = INODE_SLOTS_DEF,
    parameter int DISK_BLOCKS = DISK_BLOCKS_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    parameter int POINTERS_PER_FILE = POINTERS_PER_FILE_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);
    cmd_t cmd;
    sts_t sts;

    iba_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    iba_datapath #(
        .INODE_SLOTS(INODE_SLOTS), .DISK_BLOCKS(DISK_BLOCKS),
        .NAME_BYTES(NAME_BYTES), .POINTERS_PER_FILE(POINTERS_PER_FILE)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_item(s_item), .cmd(cmd), .sts(sts), .out_item(m_item)
    );

endmodule

[src/iba_checker.sv]
`include "inode_block_allocator_assert.svh"
module iba_checker
    import iba_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);
    // One item at a time: no accept while a result is pending
    `IBA_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "ready while result pending")
    // Accept is followed by a busy period
    `IBA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready && !m_valid,
        "no busy cycle after accept")
    // Failed operations report zero block
    `IBA_ASSERT_IMP(a_zero_on_error, aclk, aresetn, m_valid && m_item.status != ST_OK,
        m_item.physical_block == 7'd0, "nonzero block on error")
    // Stalled result holds
    `IBA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item),
        "result changed under stall")
endmodule

bind inode_block_allocator iba_checker u_chk (.*);
